[rtl/core/hsbt_pkg.sv]
// ============================================================================
// hsbt_pkg: shared types and constants for the hash set bucket table
// Transaction payloads, action and status codes, and the match result that
// the way-match logic hands to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hsbt_pkg;

  // Fixed widths of the transaction fields.
  localparam int IN_KEY_W = 32;
  localparam int COUNT_W  = 7;

  // Request codes. The unused code behaves as a membership test.
  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_TEST = 2'd2
  } action_t;

  // Result status codes.
  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  // Input transaction.
  typedef struct packed {
    logic [1:0]          action;
    logic [IN_KEY_W-1:0] key;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               status;
  } out_t;

  // Outcome of one bucket lookup.
  typedef struct packed {
    logic    found;
    status_t status;
    logic    inc;
    logic    dec;
  } match_res_t;

endpackage

`default_nettype wire

[rtl/core/hsbt_ram.sv]
// ============================================================================
// hsbt_ram: generic single-write, single-read RAM
// One write port and one read port, with the read data registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/hsbt_bucket_idx.sv]
// ============================================================================
// hsbt_bucket_idx: key to bucket mapping
// Computes key modulo NUM_BUCKETS as a reciprocal multiplication, split
// around the caller's product register, then a back-multiply and subtract.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsbt_bucket_idx #(
  parameter int NUM_BUCKETS = 16,
  parameter int KW          = 32
) (
  input  wire logic [KW-1:0]                   key_in,
  output logic      [2*KW+1:0]                 prod_out,
  input  wire logic [2*KW+1:0]                 prod_in,
  input  wire logic [KW-1:0]                   key_q,
  output logic      [$clog2(NUM_BUCKETS)-1:0]  bucket
);

  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int MUL_W  = KW + 2;
  localparam int PROD_W = 2 * KW + 2;
  localparam int R_W    = KW + BKT_W + 1;
  // Rounded-up reciprocal; exact quotients for every key below 2**KW.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (KW + BKT_W)) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

  logic [PROD_W-1:0] shifted;
  logic [KW-1:0]     quot;
  logic [R_W-1:0]    back;
  logic [R_W-1:0]    rem;

  // First half: key times the reciprocal.
  assign prod_out = PROD_W'(key_in) * PROD_W'(RECIP);

  // Second half: quotient from the registered product, then the remainder.
  always_comb begin
    shifted = prod_in >> (KW + BKT_W);
    quot    = shifted[KW-1:0];
    back    = R_W'(quot) * R_W'(NUM_BUCKETS);
    rem     = R_W'(key_q) - back;
    bucket  = rem[BKT_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/core/hsbt_way_match.sv]
// ============================================================================
// hsbt_way_match: bucket row compare and update
// Compares all ways of one bucket row with the key at once and builds the
// row to write back for an add or a delete.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hsbt_way_match #(
  parameter int WAYS = 4,
  parameter int KW   = 32
) (
  input  wire logic [1:0]         action,
  input  wire logic [KW-1:0]      key,
  input  wire logic [WAYS-1:0]    row_valid,
  input  wire logic [WAYS*KW-1:0] row_keys,
  output logic      [WAYS-1:0]    new_valid,
  output logic      [WAYS*KW-1:0] new_keys,
  output hsbt_pkg::match_res_t    res
);

  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] free;
  logic [WAYS-1:0] hit_first;
  logic [WAYS-1:0] free_first;
  logic            any_hit;
  logic            any_free;

  // Parallel compare of every way, then lowest-index picks.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = row_valid[w] && (row_keys[w*KW +: KW] == key);
      free[w] = !row_valid[w];
    end
    hit_first  = hit & (~hit + WAYS'(1));
    free_first = free & (~free + WAYS'(1));
    any_hit    = |hit;
    any_free   = |free;
  end

  // Row update and result for the requested action.
  always_comb begin
    new_valid  = row_valid;
    new_keys   = row_keys;
    res.found  = any_hit;
    res.status = hsbt_pkg::ST_DONE;
    res.inc    = 1'b0;
    res.dec    = 1'b0;
    case (action)
      hsbt_pkg::ACT_ADD: begin
        if (!any_hit) begin
          if (any_free) begin
            new_valid = row_valid | free_first;
            for (int w = 0; w < WAYS; w++) begin
              if (free_first[w]) begin
                new_keys[w*KW +: KW] = key;
              end
            end
            res.inc = 1'b1;
          end else begin
            res.status = hsbt_pkg::ST_FULL;
          end
        end
      end
      hsbt_pkg::ACT_DEL: begin
        if (any_hit) begin
          new_valid = row_valid & ~hit_first;
          res.dec   = 1'b1;
        end
      end
      default: begin
        // Membership test: the row is left as it is.
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/hash_set_bucket_table.sv]
// ============================================================================
// hash_set_bucket_table: bucketed hash set of fixed-width keys
// Add, delete and membership requests on a table of NUM_BUCKETS rows of
// WAYS keys each, with a running count of stored keys.
// ============================================================================
//
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/ready    hsbt_pkg::in_t  (action, key)
//   out_     output     out_valid/ready   hsbt_pkg::out_t (found, count, status)
//
// One transaction is accepted per cycle while in_ready is high; each request
// passes input register, reciprocal product, bucket row read and result stages.
// The bucket row memory has one read and one write port; a row written by
// one request is forwarded to a request for the same bucket right behind it.
// After reset a clearing pass zeroes every row, and no request is accepted
// until it ends. A stalled result holds the pipeline stages behind it, while
// empty stages keep filling.
`timescale 1ns / 1ps
`default_nettype none

module hash_set_bucket_table #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4,
  parameter int KEY_BITS    = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hsbt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hsbt_pkg::out_t      out_data
);

  localparam int KW     = (KEY_BITS < hsbt_pkg::IN_KEY_W) ? KEY_BITS : hsbt_pkg::IN_KEY_W;
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int SLOTS  = NUM_BUCKETS * WAYS;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ROW_W  = WAYS * (KW + 1);
  localparam int PROD_W = 2 * KW + 2;

  // Pipeline control.
  logic v0_r, v0_nxt;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic out_valid_r, out_valid_nxt;
  logic fwd2_r, fwd2_nxt;
  logic clr_busy_r, clr_busy_nxt;
  logic [BKT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic in_fire, ld1, ld2, adv2;

  // Pipeline payload.
  logic [1:0]        act0_r, act1_r, act2_r;
  logic [KW-1:0]     key0_r, key1_r, key2_r;
  logic [PROD_W-1:0] prod1_r;
  logic [PROD_W-1:0] prod0;
  logic [BKT_W-1:0]  bucket1;
  logic [BKT_W-1:0]  bucket2_r;
  logic [ROW_W-1:0]  fwd_row2_r;
  hsbt_pkg::out_t    out_data_r;

  // Row memory and way match.
  logic              ram_we;
  logic [BKT_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [BKT_W-1:0]  ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_cur;
  logic [ROW_W-1:0]  row_new;
  logic [WAYS-1:0]   new_valid;
  logic [WAYS*KW-1:0] new_keys;
  hsbt_pkg::match_res_t mres;
  logic [CNT_W+hsbt_pkg::COUNT_W-1:0] cnt_ext;

  // Stage advance: each stage moves when the one ahead is free or moving.
  always_comb begin
    adv2     = v2_r && (!out_valid_r || out_ready);
    ld2      = v1_r && (!v2_r || adv2);
    ld1      = v0_r && (!v1_r || ld2);
    in_ready = !clr_busy_r && (!v0_r || ld1);
    in_fire  = in_valid && in_ready;
  end

  // Next state of the valid flags, forwarding flag and clearing pass.
  always_comb begin
    v0_nxt = in_fire ? 1'b1 : (ld1 ? 1'b0 : v0_r);
    v1_nxt = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_r);
    v2_nxt = ld2 ? 1'b1 : (adv2 ? 1'b0 : v2_r);
    out_valid_nxt = adv2 ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    if (ld2) begin
      fwd2_nxt = adv2 && (bucket1 == bucket2_r);
    end else if (adv2) begin
      fwd2_nxt = 1'b0;
    end else begin
      fwd2_nxt = fwd2_r;
    end
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + BKT_W'(1);
      if (clr_idx_r == BKT_W'(NUM_BUCKETS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // Stored key count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (adv2) begin
      if (mres.inc) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (mres.dec && (cnt_r != '0)) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
    cnt_ext = {{hsbt_pkg::COUNT_W{1'b0}}, cnt_nxt};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fwd2_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
    end else begin
      v0_r        <= v0_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      fwd2_r      <= fwd2_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers along the pipeline.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act0_r <= in_data.action;
      key0_r <= in_data.key[KW-1:0];
    end
    if (ld1) begin
      act1_r  <= act0_r;
      key1_r  <= key0_r;
      prod1_r <= prod0;
    end
    if (ld2) begin
      act2_r     <= act1_r;
      key2_r     <= key1_r;
      bucket2_r  <= bucket1;
      fwd_row2_r <= row_new;
    end
    if (adv2) begin
      out_data_r.found  <= mres.found;
      out_data_r.count  <= cnt_ext[hsbt_pkg::COUNT_W-1:0];
      out_data_r.status <= mres.status;
    end
  end

  // Key to bucket index.
  hsbt_bucket_idx #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KW          (KW)
  ) u_bucket_idx (
    .key_in   (key0_r),
    .prod_out (prod0),
    .prod_in  (prod1_r),
    .key_q    (key1_r),
    .bucket   (bucket1)
  );

  // Row memory: the clearing pass owns the write port until it ends.
  always_comb begin
    ram_raddr = ld2 ? bucket1 : bucket2_r;
    ram_we    = clr_busy_r || adv2;
    ram_waddr = clr_busy_r ? clr_idx_r : bucket2_r;
    ram_wdata = clr_busy_r ? '0 : row_new;
  end

  hsbt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The row under test, forwarded when the previous request just wrote it.
  assign row_cur = fwd2_r ? fwd_row2_r : ram_rdata;
  assign row_new = {new_keys, new_valid};

  hsbt_way_match #(
    .WAYS (WAYS),
    .KW   (KW)
  ) u_way_match (
    .action    (act2_r),
    .key       (key2_r),
    .row_valid (row_cur[WAYS-1:0]),
    .row_keys  (row_cur[ROW_W-1:WAYS]),
    .new_valid (new_valid),
    .new_keys  (new_keys),
    .res       (mres)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // No request enters while the clearing pass runs.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("request accepted during clearing pass");

  // A rejected add never reports the key as present.
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == hsbt_pkg::ST_FULL)) |-> !out_data_r.found)
    else $error("full status together with found");

  // A forwarded row only ever belongs to a live request.
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd2_r |-> v2_r)
    else $error("forwarded row without a request in the row stage");

  // The count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("stored count above table capacity");

endmodule

`default_nettype wire
